FILE: rtl/radial_distance_stats_defines.svh
// Assertion macros for the radial distance statistics block
`ifndef RADIAL_DISTANCE_STATS_DEFINES_SVH
`define RADIAL_DISTANCE_STATS_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define RDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define RDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/rds_pkg.sv
// Shared constants and item types of the radial distance statistics block
package rds_pkg;
    localparam int COORD_BITS     = 12;
    localparam int CENTER_W       = 16;
    localparam int DIST_W         = 21;
    localparam int SUM_W          = 31;
    localparam int CIRC_W         = 22;
    localparam int CIRC_SHIFT     = 12;
    localparam int MAX_POINTS_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 8;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [CIRC_W-1:0] CIRC_MAX = '1;

    // register indexes (byte address / 4)
    localparam logic REG_CENTER_X = 1'b0;
    localparam logic REG_CENTER_Y = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic                  last_point;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] mean_radius;
        logic [CIRC_W-1:0] circularity;
        logic              radius_zero;
    } t_out_item;
endpackage

FILE: rtl/rds_dist.sv
// Distance unit: bit-serial square-and-add, then digit-by-digit square root
module rds_dist #(
    parameter int FRAC_BITS = rds_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [rds_pkg::COORD_BITS-1:0]  i_px,
    input  logic [rds_pkg::COORD_BITS-1:0]  i_py,
    input  logic [rds_pkg::CENTER_W-1:0]    i_cx,
    input  logic [rds_pkg::CENTER_W-1:0]    i_cy,
    output logic                            o_done,
    output logic [rds_pkg::DIST_W-1:0]      o_dist
);
    localparam int PW   = rds_pkg::COORD_BITS + 4;
    localparam int DW   = (PW > rds_pkg::CENTER_W) ? PW : rds_pkg::CENTER_W;
    localparam int SW   = 2 * DW + 1;
    localparam int RADW = 2 * rds_pkg::DIST_W;
    localparam int RW0  = SW + 2 * FRAC_BITS;
    localparam int RW   = (RW0 > RADW) ? RW0 : RADW + 1;
    localparam int REMW = rds_pkg::DIST_W + 2;
    localparam int CTW  = $clog2(((DW > rds_pkg::DIST_W) ? DW : rds_pkg::DIST_W) + 1);

    typedef enum logic [1:0] {S_IDLE, S_SQ, S_ROOT} t_state;

    t_state                    r_state;
    logic [DW-1:0]             r_dx, r_dy;
    logic [DW-1:0]             r_mx, r_my;
    logic [SW-1:0]             r_acc;
    logic [RADW-1:0]           r_rad;
    logic [REMW-1:0]           r_rem;
    logic [rds_pkg::DIST_W-1:0] r_root;
    logic [CTW-1:0]            r_cnt;
    logic                      r_done;

    logic [DW-1:0]   n_dx, n_dy, px_w, py_w;
    logic [SW-1:0]   sq_add;
    logic [RW-1:0]   rad_full;
    logic            rad_ovf;
    logic [REMW-1:0] rem_in, trial;

    // absolute offsets in 1/16 units
    assign px_w = DW'({i_px, 4'b0000});
    assign py_w = DW'({i_py, 4'b0000});
    assign n_dx = (px_w >= DW'(i_cx)) ? px_w - DW'(i_cx) : DW'(i_cx) - px_w;
    assign n_dy = (py_w >= DW'(i_cy)) ? py_w - DW'(i_cy) : DW'(i_cy) - py_w;

    // one multiplier bit per cycle, MSB first, both squares together;
    // r_mx/r_my hold the multiplicands while r_dx/r_dy shift out the bits
    assign sq_add = (r_dx[DW-1] ? SW'(r_mx) : '0) + (r_dy[DW-1] ? SW'(r_my) : '0);

    // scale to FRAC_BITS fraction bits on the root; from a radicand of 2^42 up the root saturates
    assign rad_full = (RW'(r_acc) << (2 * FRAC_BITS)) >> 8;
    assign rad_ovf  = |rad_full[RW-1:RADW];

    // one root bit per cycle
    assign rem_in = {r_rem[REMW-3:0], r_rad[RADW-1:RADW-2]};
    assign trial  = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_dx    <= n_dx;
                        r_dy    <= n_dy;
                        r_mx    <= n_dx;
                        r_my    <= n_dy;
                        r_acc   <= '0;
                        r_cnt   <= CTW'(DW);
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_acc <= {r_acc[SW-2:0], 1'b0} + sq_add;
                    r_dx  <= {r_dx[DW-2:0], 1'b0};
                    r_dy  <= {r_dy[DW-2:0], 1'b0};
                    r_cnt <= r_cnt - CTW'(1);
                    if (r_cnt == CTW'(1)) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    // first cycle here: load radicand, or finish at once on overflow
                    if (r_cnt == '0) begin
                        if (rad_ovf) begin
                            r_root  <= rds_pkg::DIST_MAX;
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_rad  <= rad_full[RADW-1:0];
                            r_rem  <= '0;
                            r_root <= '0;
                            r_cnt  <= CTW'(rds_pkg::DIST_W);
                            r_acc  <= '1;
                        end
                    end else begin
                        r_rad <= {r_rad[RADW-3:0], 2'b00};
                        if (rem_in >= trial) begin
                            r_rem  <= rem_in - trial;
                            r_root <= {r_root[rds_pkg::DIST_W-2:0], 1'b1};
                        end else begin
                            r_rem  <= rem_in;
                            r_root <= {r_root[rds_pkg::DIST_W-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt - CTW'(1);
                        if (r_cnt == CTW'(1)) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_dist = r_root;
endmodule

FILE: rtl/rds_div.sv
// Shared restoring divider, one quotient bit per cycle
module rds_div #(
    parameter int DVD_W = 50,
    parameter int DVR_W = 21
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);
    localparam int CTW = $clog2(DVD_W + 1);

    logic             r_busy, r_done;
    logic [CTW-1:0]   r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DVR_W-1:0] r_rem, r_dvr;
    logic [DVR_W:0]   part;

    assign part = {r_rem, r_q[DVD_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_q    <= i_dividend;
                    r_dvr  <= i_divisor;
                    r_rem  <= '0;
                    r_cnt  <= CTW'(DVD_W);
                    r_busy <= 1'b1;
                end
            end else begin
                if (part >= {1'b0, r_dvr}) begin
                    r_rem <= DVR_W'(part - {1'b0, r_dvr});
                    r_q   <= {r_q[DVD_W-2:0], 1'b1};
                end else begin
                    r_rem <= part[DVR_W-1:0];
                    r_q   <= {r_q[DVD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CTW'(1);
                if (r_cnt == CTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: rtl/radial_distance_stats.sv
// Top level: point intake, distance store, set statistics and register port
//
//  channel  | dir | handshake                   | payload
//  ---------+-----+-----------------------------+---------------------------
//  in       | in  | i_in_valid / o_in_ready     | i_in_item  (t_in_item)
//  out      | out | o_out_valid / i_out_ready   | o_out_item (t_out_item)
//  config   | in  | psel, penable, pwrite       | paddr, pwdata, prdata
//
// Intake takes a new point only after the distance of the previous one is done; that
// work is set by the bit-serial squaring and the one-bit-per-cycle root. A last point
// then adds the store walk (one memory read a cycle), two passes of the shared divider
// (the second pass is skipped when the mean is zero) and the loading of the result.
// Reset clears control state; the distance store is not cleared.
// A waiting result does not block intake; only a second result waits for it.
module radial_distance_stats #(
    parameter int MAX_POINTS = rds_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = rds_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rds_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rds_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DEV_W  = rds_pkg::DIST_W + CNT_W;
    localparam int CDV_W  = DEV_W + rds_pkg::CIRC_SHIFT;
    localparam int DVD_W  = (CDV_W > rds_pkg::SUM_W) ? CDV_W : rds_pkg::SUM_W;
    localparam int DVR_W  = (CNT_W > rds_pkg::DIST_W) ? CNT_W : rds_pkg::DIST_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DIST, S_MEAN_GO, S_MEAN_WAIT, S_WALK, S_CIRC_GO, S_CIRC_WAIT, S_OUT
    } t_state;

    t_state                      r_state;
    logic [rds_pkg::CENTER_W-1:0] r_cx, r_cy;
    logic [CNT_W-1:0]            r_count, r_idx;
    logic [rds_pkg::SUM_W-1:0]   r_sum;
    logic [DEV_W-1:0]            r_dev;
    logic [rds_pkg::DIST_W-1:0]  r_mean;
    logic [rds_pkg::CIRC_W-1:0]  r_circ;
    rds_pkg::t_in_item           r_item;
    rds_pkg::t_out_item          r_out;
    logic                        r_out_valid;
    logic                        r_rd_vld;
    logic [rds_pkg::DIST_W-1:0]  r_rd_data;
    logic [rds_pkg::DIST_W-1:0]  r_mem [MAX_POINTS];

    logic                        in_acc, cfg_wr;
    logic                        dist_start, dist_done;
    logic [rds_pkg::DIST_W-1:0]  dist_val;
    logic                        div_start, div_done;
    logic [DVD_W-1:0]            div_dvd, div_q;
    logic [DVR_W-1:0]            div_dvr;
    logic [rds_pkg::SUM_W:0]     sum_ext;
    logic [rds_pkg::DIST_W-1:0]  dev_term;
    logic                        mem_we, mem_re;
    logic                        full;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign full       = (r_count == CNT_W'(MAX_POINTS));

    // register port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            rds_pkg::REG_CENTER_X: prdata = 32'(r_cx);
            rds_pkg::REG_CENTER_Y: prdata = 32'(r_cy);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == rds_pkg::REG_CENTER_X) begin
                r_cx <= pwdata[rds_pkg::CENTER_W-1:0];
            end else begin
                r_cy <= pwdata[rds_pkg::CENTER_W-1:0];
            end
        end
    end

    // distance unit
    assign dist_start = in_acc && !full;
    rds_dist #(.FRAC_BITS(FRAC_BITS)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dist_start),
        .i_px    (i_in_item.point_x),
        .i_py    (i_in_item.point_y),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .o_done  (dist_done),
        .o_dist  (dist_val)
    );

    // shared divider: mean first, then circularity
    assign div_start = (r_state == S_MEAN_GO) || ((r_state == S_CIRC_GO) && (r_mean != '0));
    always_comb begin
        if (r_state == S_MEAN_GO) begin
            div_dvd = DVD_W'(r_sum);
            div_dvr = DVR_W'(r_count);
        end else begin
            div_dvd = DVD_W'({r_dev, {rds_pkg::CIRC_SHIFT{1'b0}}});
            div_dvr = DVR_W'(r_mean);
        end
    end
    rds_div #(.DVD_W(DVD_W), .DVR_W(DVR_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvr),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // distance store
    assign mem_we = (r_state == S_DIST) && dist_done;
    assign mem_re = (r_state == S_WALK) && (r_idx != r_count);
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[AW-1:0]] <= dist_val;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    assign sum_ext  = {1'b0, r_sum} + (rds_pkg::SUM_W+1)'(dist_val);
    assign dev_term = (r_rd_data >= r_mean) ? r_rd_data - r_mean : r_mean - r_rd_data;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            // a result taken here is replaced in S_OUT instead
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_item <= i_in_item;
                        if (!full) begin
                            r_state <= S_DIST;
                        end else if (i_in_item.last_point) begin
                            r_state <= S_MEAN_GO;
                        end
                    end
                end
                S_DIST: begin
                    if (dist_done) begin
                        r_count <= r_count + CNT_W'(1);
                        r_sum   <= sum_ext[rds_pkg::SUM_W] ? rds_pkg::SUM_MAX
                                                           : sum_ext[rds_pkg::SUM_W-1:0];
                        r_state <= r_item.last_point ? S_MEAN_GO : S_IDLE;
                    end
                end
                S_MEAN_GO: r_state <= S_MEAN_WAIT;
                S_MEAN_WAIT: begin
                    if (div_done) begin
                        r_mean   <= (div_q > DVD_W'(rds_pkg::DIST_MAX)) ? rds_pkg::DIST_MAX
                                                                      : div_q[rds_pkg::DIST_W-1:0];
                        r_idx    <= '0;
                        r_dev    <= '0;
                        r_rd_vld <= 1'b0;
                        r_state  <= S_WALK;
                    end
                end
                S_WALK: begin
                    // read one entry a cycle, add the previous one
                    r_rd_vld <= mem_re;
                    if (mem_re) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (r_rd_vld) begin
                        r_dev <= r_dev + DEV_W'(dev_term);
                    end
                    if (!mem_re && !r_rd_vld) begin
                        r_state <= S_CIRC_GO;
                    end
                end
                S_CIRC_GO: begin
                    if (r_mean == '0) begin
                        r_circ  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CIRC_WAIT;
                    end
                end
                S_CIRC_WAIT: begin
                    if (div_done) begin
                        r_circ  <= (div_q > DVD_W'(rds_pkg::CIRC_MAX)) ? rds_pkg::CIRC_MAX
                                                                     : div_q[rds_pkg::CIRC_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // load the output register once it is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out.mean_radius <= r_mean;
                        r_out.circularity <= r_circ;
                        r_out.radius_zero <= (r_mean == '0);
                        r_out_valid       <= 1'b1;
                        r_count           <= '0;
                        r_sum             <= '0;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`include "radial_distance_stats_defines.svh"

    `RDS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_POINTS), "point count above store depth")
    `RDS_ASSERT_IMP(a_zero_circ, i_clk, i_rst_n, r_out_valid && r_out.radius_zero, r_out.circularity == '0, "circularity set with zero radius")
    `RDS_ASSERT_NXT(a_one_item, i_clk, i_rst_n, in_acc && !(full && !i_in_item.last_point), !o_in_ready, "item taken while busy")
    `RDS_ASSERT_NXT(a_clear_set, i_clk, i_rst_n, (r_state == S_OUT) && (!r_out_valid || i_out_ready), (r_count == '0) && (r_sum == '0), "set not cleared after result")
endmodule
